FILE: rtl/core/hybrid_logical_clock_macros.svh
// Assertion macros used by the hybrid logical clock RTL.
`ifndef HYBRID_LOGICAL_CLOCK_MACROS_SVH
`define HYBRID_LOGICAL_CLOCK_MACROS_SVH

// Check a property on a named clock, disabled while the named reset is low.
`define HLC_ASSERT_CLK(label, ck, rst_n, prop, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on the block clock clk with reset arst_n.
`define HLC_ASSERT(label, prop, msg) \
	`HLC_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

FILE: rtl/core/hlc_pkg.sv
// Types and constants of the hybrid logical clock.
package hlc_pkg;

	localparam int PHYS_W = 48;
	localparam int LOG_W  = 16;
	localparam int NODE_W = 16;

	localparam logic [LOG_W-1:0] LOG_MAX = {LOG_W{1'b1}};

	typedef enum logic [0:0] {
		KIND_LOCAL = 1'b0,
		KIND_RECV  = 1'b1
	} hlc_kind_t;

	// One request as held in the input register.
	typedef struct packed {
		hlc_kind_t         kind;
		logic [PHYS_W-1:0] wall_now;
		logic [PHYS_W-1:0] remote_physical;
		logic [LOG_W-1:0]  remote_logical;
	} hlc_item_t;

	// One result timestamp.
	typedef struct packed {
		logic [PHYS_W-1:0] out_physical;
		logic [LOG_W-1:0]  out_logical;
		logic [NODE_W-1:0] out_node;
		logic              wrapped;
	} hlc_result_t;

endpackage

FILE: rtl/core/hlc_update.sv
// Clock state, node id register and the per-request update rule.
`include "hybrid_logical_clock_macros.svh"

module hlc_update
	import hlc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  hlc_item_t         item,
	input  logic              cfg_we,
	input  logic [NODE_W-1:0] cfg_wdata,
	output hlc_result_t       result
);

	logic [PHYS_W-1:0] phys_q;
	logic [LOG_W-1:0]  log_q;
	logic [NODE_W-1:0] node_q;

	logic [PHYS_W-1:0] next_phys;
	logic [LOG_W-1:0]  next_log;
	logic [LOG_W-1:0]  bump_src;
	logic              take_wall;
	logic              wrap;

	logic now_gt_clk;
	logic now_gt_rp;
	logic clk_eq_rp;
	logic clk_gt_rp;
	logic [LOG_W-1:0] log_max;

	// Compare the clock against wall time and the remote timestamp
	assign now_gt_clk = item.wall_now > phys_q;
	assign now_gt_rp  = item.wall_now > item.remote_physical;
	assign clk_eq_rp  = phys_q == item.remote_physical;
	assign clk_gt_rp  = phys_q > item.remote_physical;
	assign log_max    = (log_q > item.remote_logical) ? log_q : item.remote_logical;

	// Pick the new physical time and the counter to advance
	always_comb begin
		next_phys = phys_q;
		bump_src  = log_q;
		take_wall = 1'b0;
		case (item.kind)
			KIND_LOCAL: begin
				take_wall = now_gt_clk;
			end
			KIND_RECV: begin
				if (now_gt_clk && now_gt_rp) begin
					take_wall = 1'b1;
				end else if (clk_eq_rp) begin
					bump_src = log_max;
				end else if (clk_gt_rp) begin
					bump_src = log_q;
				end else begin
					next_phys = item.remote_physical;
					bump_src  = item.remote_logical;
				end
			end
			default: begin
				take_wall = 1'b0;
			end
		endcase
		if (take_wall) begin
			next_phys = item.wall_now;
		end
	end

	// Advance the counter, wrapping from the maximum to zero, or clear it when wall time is taken
	always_comb begin
		if (take_wall) begin
			next_log = '0;
			wrap     = 1'b0;
		end else begin
			next_log = bump_src + LOG_W'(1);
			wrap     = bump_src == LOG_MAX;
		end
	end

	assign result.out_physical = next_phys;
	assign result.out_logical  = next_log;
	assign result.out_node     = node_q;
	assign result.wrapped      = wrap;

	// Commit the new clock when the request moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phys_q <= '0;
			log_q  <= '0;
		end else if (en) begin
			phys_q <= next_phys;
			log_q  <= next_log;
		end
	end

	// Hold the node id
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q <= '0;
		end else if (cfg_we) begin
			node_q <= cfg_wdata;
		end
	end

	`HLC_ASSERT(a_phys_monotonic, en |-> next_phys >= phys_q, "physical time moved backward")
	`HLC_ASSERT(a_wrap_gives_zero, (en && wrap) |-> next_log == '0, "wrap without zero counter")
	`HLC_ASSERT(a_same_phys_bumps, (en && next_phys == phys_q && !wrap) |-> next_log > log_q,
		"timestamp did not advance")
	`HLC_ASSERT(a_commit, en |=> (phys_q == $past(next_phys)) && (log_q == $past(next_log)),
		"clock state not committed")

endmodule

FILE: rtl/core/hlc_out_stage.sv
// Result register driving the output stream.
module hlc_out_stage
	import hlc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  hlc_result_t in_result,
	output logic        advance,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,
	output logic [0:0]  m_axis_tuser
);

	logic        valid_q;
	hlc_result_t res_q;

	// Take a new result when the register is empty or being drained
	assign advance = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			res_q <= in_result;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {res_q.out_node, res_q.out_logical, res_q.out_physical};
	assign m_axis_tuser  = res_q.wrapped;

endmodule

FILE: rtl/core/hybrid_logical_clock.sv
// Top level of the hybrid logical clock: input register, update and result register.
//
// Channel  Dir  Contents (low bit first)
// s_axis   in   tdata: wall_now[47:0], remote_physical[95:48], remote_logical[111:96]
//               tuser: kind[0]
// m_axis   out  tdata: out_physical[47:0], out_logical[63:48], out_node[79:64]
//               tuser: wrapped[0]
// cfg      in   cfg_we, cfg_wdata: node_ident[15:0]
//
// One request per cycle sustained while the output is not stalled; each result passes
// through the input register and the result register before it is presented.
// The clock state is updated as a request leaves the input register, so the
// next request sees it in the following cycle.
// Reset clears the clock to zero physical time and zero counter, and node id to 0.
// A stalled output holds its result; the input register still takes one more request.

module hybrid_logical_clock
	import hlc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [111:0] s_axis_tdata,   // wall_now, remote_physical, remote_logical
	input  logic [0:0]   s_axis_tuser,   // kind
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [79:0]  m_axis_tdata,   // out_physical, out_logical, out_node
	output logic [0:0]   m_axis_tuser,   // wrapped
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata
);

	logic        valid_s1;
	hlc_item_t   item_s1;
	logic        advance;
	logic        en;
	hlc_result_t result;

	assign s_axis_tready = !valid_s1 || advance;
	assign en            = valid_s1 && advance;

	// Load the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.kind            <= hlc_kind_t'(s_axis_tuser[0]);
			item_s1.wall_now        <= s_axis_tdata[47:0];
			item_s1.remote_physical <= s_axis_tdata[95:48];
			item_s1.remote_logical  <= s_axis_tdata[111:96];
		end
	end

	hlc_update u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.item      (item_s1),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (result)
	);

	hlc_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (valid_s1),
		.in_result     (result),
		.advance       (advance),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

FILE: tb/sv/tb_hybrid_logical_clock.sv
// Self-checking testbench for the hybrid logical clock: directed and random requests, scoreboarded.
module tb_hybrid_logical_clock;
	import hlc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned PHASE_ITEMS = 90;
	localparam logic [PHYS_W-1:0] PHYS_MAX = {PHYS_W{1'b1}};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [111:0] s_axis_tdata = '0;   // wall_now, remote_physical, remote_logical
	logic [0:0]   s_axis_tuser = '0;   // kind
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [79:0]  m_axis_tdata;        // out_physical, out_logical, out_node
	logic [0:0]   m_axis_tuser;        // wrapped
	logic         cfg_we = 1'b0;
	logic [15:0]  cfg_wdata = '0;

	// Stimulus and scoreboard state
	hlc_item_t   requests_pending[$];
	hlc_result_t stamps_due[$];
	hlc_item_t   tx_item;
	int unsigned tx_gap = 0;
	int unsigned rx_gap = 0;
	bit          no_gaps = 1'b0;
	int unsigned issued = 0;
	int unsigned retired = 0;
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned local_count = 0;
	int unsigned recv_count = 0;
	int unsigned wrap_count = 0;
	int unsigned node_writes = 0;

	// Mirror of the clock state and node id
	logic [PHYS_W-1:0] hlc_phys = '0;
	logic [LOG_W-1:0]  hlc_log = '0;
	logic [NODE_W-1:0] node_id = '0;

	// Generator's view of the physical time: the largest time issued so far
	logic [PHYS_W-1:0] gen_phys = '0;

	hybrid_logical_clock dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always #4 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d timestamps outstanding", cycles,
				issued - retired);
			$display("FAIL hybrid_logical_clock");
			$finish;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [PHYS_W-1:0] rand48();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[PHYS_W-1:0];
	endfunction

	// Saturating moves of a physical time
	function automatic logic [PHYS_W-1:0] step_up(logic [PHYS_W-1:0] base, int unsigned d);
		logic [PHYS_W:0] s;
		s = {1'b0, base} + (PHYS_W+1)'(d);
		return s[PHYS_W] ? PHYS_MAX : s[PHYS_W-1:0];
	endfunction

	function automatic logic [PHYS_W-1:0] step_down(logic [PHYS_W-1:0] base, int unsigned d);
		return (base > PHYS_W'(d)) ? base - PHYS_W'(d) : '0;
	endfunction

	// Increment a counter; the carry marks a wrap to zero
	function automatic logic [LOG_W:0] bump(logic [LOG_W-1:0] c);
		return {1'b0, c} + (LOG_W+1)'(1);
	endfunction

	// Apply one event to the mirrored clock and return the timestamp it yields
	function automatic hlc_result_t advance_hlc(hlc_kind_t kind, logic [PHYS_W-1:0] now,
			logic [PHYS_W-1:0] rphys, logic [LOG_W-1:0] rlog);
		hlc_result_t res;
		logic [LOG_W:0] sum;
		logic [LOG_W-1:0] top;
		sum = '0;
		if (kind == KIND_LOCAL) begin
			if (now > hlc_phys) begin
				hlc_phys = now;
				hlc_log = '0;
			end else begin
				sum = bump(hlc_log);
				hlc_log = sum[LOG_W-1:0];
			end
		end else if (now > hlc_phys && now > rphys) begin
			hlc_phys = now;
			hlc_log = '0;
		end else if (hlc_phys == rphys) begin
			top = (hlc_log > rlog) ? hlc_log : rlog;
			sum = bump(top);
			hlc_log = sum[LOG_W-1:0];
		end else if (hlc_phys > rphys) begin
			sum = bump(hlc_log);
			hlc_log = sum[LOG_W-1:0];
		end else begin
			hlc_phys = rphys;
			sum = bump(rlog);
			hlc_log = sum[LOG_W-1:0];
		end
		res.out_physical = hlc_phys;
		res.out_logical = hlc_log;
		res.out_node = node_id;
		res.wrapped = sum[LOG_W];
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycles, what, got, want);
	endtask

	// Queue one request and track the largest time it can bring in
	task automatic queue_event(hlc_kind_t kind, logic [PHYS_W-1:0] now,
			logic [PHYS_W-1:0] rphys, logic [LOG_W-1:0] rlog);
		hlc_item_t it;
		it.kind = kind;
		it.wall_now = now;
		it.remote_physical = rphys;
		it.remote_logical = rlog;
		requests_pending.push_back(it);
		issued++;
		if (now > gen_phys)
			gen_phys = now;
		if (kind == KIND_RECV && rphys > gen_phys)
			gen_phys = rphys;
	endtask

	// Mostly well-formed events around the current time, some noise
	task automatic queue_random_event();
		int unsigned pick;
		hlc_kind_t kind;
		logic [PHYS_W-1:0] now;
		logic [PHYS_W-1:0] rphys;
		logic [LOG_W-1:0] rlog;
		pick = $urandom_range(0, 99);
		kind = KIND_RECV;
		now = rand48();
		rphys = rand48();
		rlog = ($urandom_range(0, 3) == 0) ? LOG_MAX - LOG_W'($urandom_range(0, 2))
			: LOG_W'($urandom);
		if (pick < 22) begin
			kind = KIND_LOCAL;
			now = step_up(gen_phys, $urandom_range(1, 3));
		end else if (pick < 40) begin
			kind = KIND_LOCAL;
			now = step_down(gen_phys, $urandom_range(0, 20));
		end else if (pick < 55) begin
			rphys = gen_phys;
			now = step_down(gen_phys, $urandom_range(0, 20));
		end else if (pick < 67) begin
			rphys = step_down(gen_phys, $urandom_range(1, 50));
			now = step_down(gen_phys, $urandom_range(0, 20));
		end else if (pick < 79) begin
			rphys = step_up(gen_phys, $urandom_range(1, 5));
			now = step_down(rphys, $urandom_range(0, 10));
		end else if (pick < 92) begin
			now = step_up(gen_phys, $urandom_range(2, 6));
			rphys = step_down(now, $urandom_range(1, 10));
		end else begin
			kind = hlc_kind_t'($urandom_range(0, 1));
		end
		queue_event(kind, now, rphys, rlog);
	endtask

	// Hold until every timestamp has come back, then let the pipeline settle
	task automatic wait_drained();
		while (retired != issued)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_node(logic [NODE_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		node_id = value;
		node_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Driver: present pending requests with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (requests_pending.size() > 0) begin
					tx_item = requests_pending.pop_front();
					s_axis_tdata <= {tx_item.remote_logical, tx_item.remote_physical,
						tx_item.wall_now};
					s_axis_tuser <= tx_item.kind;
					s_axis_tvalid <= 1'b1;
					tx_gap = pick_gap();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: predict on each accepted request, check each accepted timestamp
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				stamps_due.push_back(advance_hlc(hlc_kind_t'(s_axis_tuser[0]),
					s_axis_tdata[47:0], s_axis_tdata[95:48], s_axis_tdata[111:96]));
				if (s_axis_tuser[0] == KIND_LOCAL)
					local_count++;
				else
					recv_count++;
				if (stamps_due[$].wrapped)
					wrap_count++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (stamps_due.size() == 0) begin
					report_mismatch("unexpected timestamp", m_axis_tdata[47:0], 0);
				end else begin
					if (m_axis_tdata[47:0] != stamps_due[0].out_physical)
						report_mismatch("out_physical", m_axis_tdata[47:0],
							stamps_due[0].out_physical);
					if (m_axis_tdata[63:48] != stamps_due[0].out_logical)
						report_mismatch("out_logical", m_axis_tdata[63:48],
							stamps_due[0].out_logical);
					if (m_axis_tdata[79:64] != stamps_due[0].out_node)
						report_mismatch("out_node", m_axis_tdata[79:64],
							stamps_due[0].out_node);
					if (m_axis_tuser[0] != stamps_due[0].wrapped)
						report_mismatch("wrapped", m_axis_tuser[0], stamps_due[0].wrapped);
					void'(stamps_due.pop_front());
					retired++;
				end
			end
			// Stall the result side at random
			if (rx_gap > 0) begin
				rx_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					rx_gap = pick_gap();
			end
		end
	end

	// Sequence the phases: directed cases, random phases, saturated time
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		write_node(16'hFFFF);
		queue_event(KIND_LOCAL, 48'd0, 48'd0, 16'd0);          // wall equal to zero clock
		queue_event(KIND_LOCAL, 48'd1000, 48'd0, 16'd0);       // wall ahead
		queue_event(KIND_LOCAL, 48'd500, 48'd0, 16'd0);        // wall behind
		queue_event(KIND_RECV, 48'd2000, 48'd1500, 16'd7);     // wall ahead of both
		queue_event(KIND_RECV, 48'd10, 48'd2000, 16'd5);       // equal, remote larger
		queue_event(KIND_RECV, 48'd10, 48'd2000, 16'd1);       // equal, local larger
		queue_event(KIND_RECV, 48'd10, 48'd100, 16'd9);        // local ahead
		queue_event(KIND_RECV, 48'd10, 48'd5000, 16'd3);       // remote ahead
		queue_event(KIND_RECV, 48'd5000, 48'd5000, LOG_MAX);   // equal, wraps
		queue_event(KIND_RECV, 48'd0, 48'd5000, 16'hFFFE);     // counter to max
		queue_event(KIND_LOCAL, 48'd5000, 48'd0, 16'd0);       // local wrap
		queue_event(KIND_RECV, 48'd0, 48'd6000, LOG_MAX);      // remote ahead, wraps
		queue_event(KIND_RECV, 48'd7000, 48'd7000, 16'd3);     // wall ties remote
		queue_event(KIND_RECV, 48'd8000, 48'd7000, 16'd0);     // wall ahead
		queue_event(KIND_RECV, 48'd8000, 48'd8000, 16'hFFFE);  // equal, to max
		queue_event(KIND_RECV, 48'd0, 48'd1, LOG_MAX);         // local ahead, wraps
		queue_event(KIND_RECV, 48'd8001, 48'd8001, 16'd2);     // remote ahead by one
		wait_drained();

		// Random phases, each under its own node id
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: write_node(16'h0001);
				2: write_node(16'h8000);
				4: write_node(16'h7FFF);
				default: write_node(NODE_W'($urandom));
			endcase
			no_gaps = (p == 2);
			for (int i = 0; i < PHASE_ITEMS; i++)
				queue_random_event();
			wait_drained();
		end
		no_gaps = 1'b0;

		// Drive the clock to the top of its physical range last: it never comes back down
		write_node(16'h0000);
		queue_event(KIND_RECV, PHYS_MAX, 48'd0, LOG_MAX);
		queue_event(KIND_LOCAL, PHYS_MAX, 48'd0, 16'd0);
		queue_event(KIND_RECV, 48'd0, PHYS_MAX, 16'd0);
		queue_event(KIND_RECV, PHYS_MAX, PHYS_MAX, 16'hFFFE);
		queue_event(KIND_LOCAL, 48'd0, 48'd0, 16'd0);
		for (int i = 0; i < 20; i++)
			queue_random_event();
		wait_drained();

		$display("covered %0d events (%0d local, %0d receive) with %0d counter wraps",
			issued, local_count, recv_count, wrap_count);
		$display("across %0d node id settings, both sides idling and stalling at random",
			node_writes);
		if (errors == 0) begin
			$display("PASS hybrid_logical_clock");
		end else begin
			$display("%0d mismatches", errors);
			$display("FAIL hybrid_logical_clock");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/hlc_pkg.sv
rtl/core/hlc_update.sv
rtl/core/hlc_out_stage.sv
rtl/core/hybrid_logical_clock.sv
tb/sv/tb_hybrid_logical_clock.sv
